FILE: rtl/bchr_pkg.sv
`timescale 1ns / 1ps

package bchr_pkg;

  // Store geometry
  localparam int NUM_BUTTONS = 16;
  localparam int BTN_IDX_W   = 4;
  localparam int TIMER_W     = 16;
  localparam int CLICK_W     = 8;
  localparam int FLAG_W      = 6;

  // Command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TAKE  = 2'd2;
  localparam logic [1:0] CMD_MATCH = 2'd3;

  // Configuration register indexes
  localparam int         REG_IDX_W        = 3;
  localparam logic [2:0] REG_BUTTONS      = 3'd0;
  localparam logic [2:0] REG_ACTIVE_LOW   = 3'd1;
  localparam logic [2:0] REG_BOUNCE       = 3'd2;
  localparam logic [2:0] REG_CLICK_GAP    = 3'd3;
  localparam logic [2:0] REG_HOLD         = 3'd4;
  localparam logic [2:0] REG_REPEAT       = 3'd5;

  // Event flag bit positions
  localparam int F_ON_PRESS = 0;
  localparam int F_PRESSED  = 1;
  localparam int F_ON_HOLD  = 2;
  localparam int F_HELD     = 3;
  localparam int F_RELEASED = 4;
  localparam int F_REPEAT   = 5;

  typedef enum logic [2:0] {
    MODE_WAIT     = 3'd0,
    MODE_DEBOUNCE = 3'd1,
    MODE_COUNT    = 3'd2,
    MODE_HOLD     = 3'd3,
    MODE_RELEASE  = 3'd4
  } mode_t;

  typedef struct packed {
    mode_t                mode;
    logic [TIMER_W-1:0]   tick_timer;
    logic [TIMER_W-1:0]   gap_timer;
    logic [CLICK_W-1:0]   click_count;
    logic [FLAG_W-1:0]    flags;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [4:0]           buttons_in_use;
    logic [15:0]          active_low_mask;
    logic [TIMER_W-1:0]   bounce_ticks;
    logic [TIMER_W-1:0]   click_gap_ticks;
    logic [TIMER_W-1:0]   hold_ticks;
    logic [TIMER_W-1:0]   repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           command;
    logic [BTN_IDX_W-1:0] button_index;
    logic                 raw_level;
    logic [3:0]           clear_mask;
    logic                 hold_aware;
    logic [CLICK_W-1:0]   expected_clicks;
  } cmd_t;

  typedef struct packed {
    logic                 changed;
    logic [FLAG_W-1:0]    flags;
    logic [CLICK_W-1:0]   click_total;
    logic                 clicks_matched;
  } result_t;

endpackage

FILE: rtl/bchr_ram.sv
`timescale 1ns / 1ps

module bchr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bchr_step.sv
`timescale 1ns / 1ps

module bchr_step import bchr_pkg::*; (
  input  entry_t  cur,
  input  cmd_t    cmd,
  input  cfg_t    cfg,
  output entry_t  nxt,
  output result_t res
);

  function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
    sat_inc = (v == {TIMER_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  logic [4:0] limit;
  logic       in_use;
  logic       level;
  logic [TIMER_W-1:0] t_inc;
  logic [TIMER_W-1:0] g_inc;

  // Clamp the button count and pick the effective pin level
  always_comb begin
    limit  = (cfg.buttons_in_use > 5'(NUM_BUTTONS)) ? 5'(NUM_BUTTONS) : cfg.buttons_in_use;
    in_use = {1'b0, cmd.button_index} < limit;
    level  = cmd.raw_level ^ cfg.active_low_mask[cmd.button_index];
    t_inc  = sat_inc(cur.tick_timer);
    g_inc  = sat_inc(cur.gap_timer);
  end

  // Advance the entry for one command
  always_comb begin
    nxt                = cur;
    res.changed        = 1'b0;
    res.click_total    = cur.click_count;
    res.clicks_matched = 1'b0;
    res.flags          = cur.flags;

    case (cmd.command)
      CMD_TICK: begin
        if (in_use) begin
          case (cur.mode)
            MODE_WAIT: begin
              if (level) begin
                nxt.tick_timer       = '0;
                nxt.flags[F_PRESSED] = 1'b0;
                nxt.mode             = MODE_DEBOUNCE;
              end
              if (cur.gap_timer != '0) begin
                if (cur.gap_timer >= cfg.click_gap_ticks) begin
                  nxt.gap_timer = '0;
                  res.changed   = 1'b1;
                end else begin
                  nxt.gap_timer = g_inc;
                end
              end
            end
            MODE_DEBOUNCE: begin
              nxt.tick_timer = t_inc;
              if (t_inc >= cfg.bounce_ticks) begin
                if (level) begin
                  if (cur.gap_timer == '0) begin
                    nxt.click_count = '0;
                  end
                  nxt.flags[F_ON_PRESS] = 1'b1;
                  nxt.flags[F_PRESSED]  = 1'b1;
                  nxt.flags[F_REPEAT]   = 1'b1;
                  nxt.flags[F_RELEASED] = 1'b0;
                  nxt.flags[F_HELD]     = 1'b0;
                  nxt.gap_timer         = cfg.bounce_ticks;
                  nxt.mode              = MODE_COUNT;
                  res.changed           = 1'b1;
                end else begin
                  nxt.mode = MODE_WAIT;
                end
              end
            end
            MODE_COUNT: begin
              nxt.gap_timer = g_inc;
              if (level) begin
                nxt.tick_timer = t_inc;
                if (g_inc >= cfg.click_gap_ticks) begin
                  nxt.click_count = cur.click_count + 1'b1;
                  nxt.gap_timer   = '0;
                  nxt.mode        = MODE_HOLD;
                  res.changed     = 1'b1;
                end
              end else begin
                nxt.flags[F_ON_PRESS] = 1'b0;
                nxt.flags[F_RELEASED] = 1'b1;
                nxt.click_count       = cur.click_count + 1'b1;
                nxt.mode              = MODE_WAIT;
                res.changed           = 1'b1;
              end
            end
            MODE_HOLD: begin
              if (level) begin
                nxt.tick_timer = t_inc;
                if (t_inc >= cfg.hold_ticks) begin
                  nxt.flags[F_ON_HOLD] = 1'b1;
                  nxt.flags[F_HELD]    = 1'b1;
                  nxt.flags[F_REPEAT]  = 1'b1;
                  nxt.tick_timer       = '0;
                  nxt.mode             = MODE_RELEASE;
                  res.changed          = 1'b1;
                end
              end else begin
                nxt.flags[F_ON_PRESS] = 1'b0;
                nxt.flags[F_RELEASED] = 1'b1;
                nxt.mode              = MODE_WAIT;
                res.changed           = 1'b1;
              end
            end
            MODE_RELEASE: begin
              if (level) begin
                nxt.tick_timer = t_inc;
                if (t_inc >= cfg.repeat_ticks) begin
                  nxt.flags[F_REPEAT] = 1'b1;
                  nxt.tick_timer      = '0;
                  res.changed         = 1'b1;
                end
              end else begin
                nxt.flags[F_ON_PRESS] = 1'b0;
                nxt.flags[F_ON_HOLD]  = 1'b0;
                nxt.flags[F_REPEAT]   = 1'b0;
                nxt.flags[F_RELEASED] = 1'b1;
                nxt.mode              = MODE_WAIT;
                res.changed           = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        res.click_total = nxt.click_count;
        res.flags       = nxt.flags;
      end
      CMD_READ: begin
        // Report flags before the clear
        if (cmd.clear_mask[0]) nxt.flags[F_PRESSED]  = 1'b0;
        if (cmd.clear_mask[1]) nxt.flags[F_RELEASED] = 1'b0;
        if (cmd.clear_mask[2]) nxt.flags[F_REPEAT]   = 1'b0;
        if (cmd.clear_mask[3]) nxt.flags[F_HELD]     = 1'b0;
      end
      CMD_TAKE: begin
        res.click_total = '0;
        if (cur.click_count != '0 && cur.gap_timer == '0) begin
          if (!cmd.hold_aware) begin
            nxt.click_count = '0;
            res.click_total = cur.click_count;
          end else if (cur.mode == MODE_RELEASE) begin
            res.click_total = cur.click_count;
          end else if (cur.mode == MODE_WAIT && !cur.flags[F_HELD]) begin
            nxt.click_count = '0;
            res.click_total = cur.click_count;
          end
        end
      end
      CMD_MATCH: begin
        if (cur.click_count == cmd.expected_clicks) begin
          nxt.gap_timer      = '0;
          nxt.click_count    = '0;
          res.clicks_matched = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/button_click_hold_repeat_fsm_unit.sv
`timescale 1ns / 1ps

// Per-button click, hold and repeat tracker for up to 16 buttons. For each
// item, the accept edge reads the button's entry from a simple dual-port
// synchronous RAM, and the next edge writes the updated entry back and loads
// the result registers. busy is high for the one cycle in between; done
// marks the result for exactly one cycle and a new start is taken in that
// same cycle, but not while busy is high. The receiver cannot stall:
// capture the result fields while done is high. Reset clears every entry at
// once through per-button valid bits; configuration writes take effect on
// the clock edge where wr_en is high and belong to idle periods.
module button_click_hold_repeat_fsm_unit import bchr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           command,
  input  logic [BTN_IDX_W-1:0] button_index,
  input  logic                 raw_level,
  input  logic [3:0]           clear_mask,
  input  logic                 hold_aware,
  input  logic [CLICK_W-1:0]   expected_clicks,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [15:0]          wr_data,
  output logic                 done,
  output logic                 changed,
  output logic                 is_pressed,
  output logic                 press_event,
  output logic                 is_held,
  output logic                 hold_event,
  output logic                 release_event,
  output logic                 repeat_event,
  output logic [CLICK_W-1:0]   click_total,
  output logic                 clicks_matched
);

  cfg_t                   cfg;
  cmd_t                   cmd;
  logic [NUM_BUTTONS-1:0] valid;
  logic                   rd_valid;
  logic [ENTRY_W-1:0]     rdata;
  entry_t                 cur;
  entry_t                 nxt;
  result_t                res;
  logic                   accept;

  assign accept = start && !busy;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buttons_in_use  <= 5'd16;
      cfg.active_low_mask <= '0;
      cfg.bounce_ticks    <= 16'd5;
      cfg.click_gap_ticks <= 16'd30;
      cfg.hold_ticks      <= 16'd100;
      cfg.repeat_ticks    <= 16'd20;
    end else if (wr_en) begin
      case (wr_index)
        REG_BUTTONS:    cfg.buttons_in_use  <= wr_data[4:0];
        REG_ACTIVE_LOW: cfg.active_low_mask <= wr_data;
        REG_BOUNCE:     cfg.bounce_ticks    <= wr_data;
        REG_CLICK_GAP:  cfg.click_gap_ticks <= wr_data;
        REG_HOLD:       cfg.hold_ticks      <= wr_data;
        REG_REPEAT:     cfg.repeat_ticks    <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // Latch the item and its entry's valid bit at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.command         <= command;
      cmd.button_index    <= button_index;
      cmd.raw_level       <= raw_level;
      cmd.clear_mask      <= clear_mask;
      cmd.hold_aware      <= hold_aware;
      cmd.expected_clicks <= expected_clicks;
      rd_valid            <= valid[button_index];
    end
  end

  // Sequence read, write-back and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      valid <= '0;
    end else begin
      done <= busy;
      busy <= accept;
      if (busy) begin
        valid[cmd.button_index] <= 1'b1;
      end
    end
  end

  // Per-button entry store
  bchr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BUTTONS)
  ) u_ram (
    .clk   (clk),
    .we    (busy),
    .waddr (cmd.button_index),
    .wdata (nxt),
    .raddr (button_index),
    .rdata (rdata)
  );

  // Never-written entries read as the reset entry
  assign cur = rd_valid ? entry_t'(rdata) : entry_t'('0);

  bchr_step u_step (
    .cur (cur),
    .cmd (cmd),
    .cfg (cfg),
    .nxt (nxt),
    .res (res)
  );

  // Register the result item
  always_ff @(posedge clk) begin
    if (busy) begin
      changed        <= res.changed;
      is_pressed     <= res.flags[F_ON_PRESS];
      press_event    <= res.flags[F_PRESSED];
      is_held        <= res.flags[F_ON_HOLD];
      hold_event     <= res.flags[F_HELD];
      release_event  <= res.flags[F_RELEASED];
      repeat_event   <= res.flags[F_REPEAT];
      click_total    <= res.click_total;
      clicks_matched <= res.clicks_matched;
    end
  end

endmodule

FILE: test/button_click_hold_repeat_fsm_checker.sv
`timescale 1ns / 1ps

module button_click_hold_repeat_fsm_checker import bchr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [1:0]           command,
  input  logic [BTN_IDX_W-1:0] button_index,
  input  logic                 raw_level,
  input  logic [3:0]           clear_mask,
  input  logic                 hold_aware,
  input  logic [CLICK_W-1:0]   expected_clicks,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [15:0]          wr_data,
  input  logic                 done,
  input  logic                 changed,
  input  logic                 is_pressed,
  input  logic                 press_event,
  input  logic                 is_held,
  input  logic                 hold_event,
  input  logic                 release_event,
  input  logic                 repeat_event,
  input  logic [CLICK_W-1:0]   click_total,
  input  logic                 clicks_matched,
  output int                   fail_count,
  output int                   open_items
);

  typedef struct packed {
    logic [1:0]           cmd;
    logic [BTN_IDX_W-1:0] button;
    result_t              res;
  } report_t;

  // Shadow copy of the per-button store and the registers
  mode_t              btn_mode [NUM_BUTTONS];
  logic [TIMER_W-1:0] tick_tmr [NUM_BUTTONS];
  logic [TIMER_W-1:0] gap_tmr  [NUM_BUTTONS];
  logic [CLICK_W-1:0] clicks   [NUM_BUTTONS];
  logic [FLAG_W-1:0]  flags    [NUM_BUTTONS];
  cfg_t               cfg;

  report_t            awaited_reports [$];
  int                 n_open;
  int                 n_fail;

  // Count up, stick at all ones
  function automatic logic [TIMER_W-1:0] bump(input logic [TIMER_W-1:0] v);
    return (v == {TIMER_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // Advance one button by one tick; return whether anything changed
  function automatic logic advance_button(input int b, input logic level);
    logic [FLAG_W-1:0] f;
    logic              ch;
    f  = flags[b];
    ch = 1'b0;
    case (btn_mode[b])
      MODE_WAIT: begin
        if (level) begin
          tick_tmr[b] = '0;
          f[F_PRESSED] = 1'b0;
          btn_mode[b] = MODE_DEBOUNCE;
        end
        // close the click series once the gap runs out
        if (gap_tmr[b] != '0) begin
          if (gap_tmr[b] >= cfg.click_gap_ticks) begin
            gap_tmr[b] = '0;
            ch = 1'b1;
          end else begin
            gap_tmr[b] = bump(gap_tmr[b]);
          end
        end
      end
      MODE_DEBOUNCE: begin
        tick_tmr[b] = bump(tick_tmr[b]);
        if (tick_tmr[b] >= cfg.bounce_ticks) begin
          if (level) begin
            if (gap_tmr[b] == '0) clicks[b] = '0;
            f[F_ON_PRESS] = 1'b1;
            f[F_PRESSED]  = 1'b1;
            f[F_REPEAT]   = 1'b1;
            f[F_RELEASED] = 1'b0;
            f[F_HELD]     = 1'b0;
            gap_tmr[b] = cfg.bounce_ticks;
            btn_mode[b] = MODE_COUNT;
            ch = 1'b1;
          end else begin
            btn_mode[b] = MODE_WAIT;
          end
        end
      end
      MODE_COUNT: begin
        gap_tmr[b] = bump(gap_tmr[b]);
        if (level) begin
          tick_tmr[b] = bump(tick_tmr[b]);
          if (gap_tmr[b] >= cfg.click_gap_ticks) begin
            clicks[b] = clicks[b] + 1'b1;
            gap_tmr[b] = '0;
            btn_mode[b] = MODE_HOLD;
            ch = 1'b1;
          end
        end else begin
          f[F_ON_PRESS] = 1'b0;
          f[F_RELEASED] = 1'b1;
          clicks[b] = clicks[b] + 1'b1;
          btn_mode[b] = MODE_WAIT;
          ch = 1'b1;
        end
      end
      MODE_HOLD: begin
        if (level) begin
          tick_tmr[b] = bump(tick_tmr[b]);
          if (tick_tmr[b] >= cfg.hold_ticks) begin
            f[F_ON_HOLD] = 1'b1;
            f[F_HELD]    = 1'b1;
            f[F_REPEAT]  = 1'b1;
            tick_tmr[b] = '0;
            btn_mode[b] = MODE_RELEASE;
            ch = 1'b1;
          end
        end else begin
          f[F_ON_PRESS] = 1'b0;
          f[F_RELEASED] = 1'b1;
          btn_mode[b] = MODE_WAIT;
          ch = 1'b1;
        end
      end
      MODE_RELEASE: begin
        if (level) begin
          tick_tmr[b] = bump(tick_tmr[b]);
          if (tick_tmr[b] >= cfg.repeat_ticks) begin
            f[F_REPEAT] = 1'b1;
            tick_tmr[b] = '0;
            ch = 1'b1;
          end
        end else begin
          f[F_ON_PRESS] = 1'b0;
          f[F_ON_HOLD]  = 1'b0;
          f[F_REPEAT]   = 1'b0;
          f[F_RELEASED] = 1'b1;
          btn_mode[b] = MODE_WAIT;
          ch = 1'b1;
        end
      end
      default: ;
    endcase
    flags[b] = f;
    return ch;
  endfunction

  // Hand out clicks once the series closes, subject to holds if asked
  function automatic logic [CLICK_W-1:0] take_clicks(input int b, input logic consider);
    logic [CLICK_W-1:0] n;
    n = clicks[b];
    if (n == '0 || gap_tmr[b] != '0) return '0;
    if (!consider) begin
      clicks[b] = '0;
      return n;
    end
    if (btn_mode[b] == MODE_HOLD) return '0;
    if (btn_mode[b] == MODE_RELEASE) return n;
    if (btn_mode[b] == MODE_WAIT && !flags[b][F_HELD]) begin
      clicks[b] = '0;
      return n;
    end
    return '0;
  endfunction

  // Apply one item to the shadow store and build the result it should give
  function automatic result_t button_report(input logic [1:0] cmd, input int b,
                                            input logic raw, input logic [3:0] clr,
                                            input logic consider,
                                            input logic [CLICK_W-1:0] want_clicks);
    result_t           r;
    int                limit;
    logic [FLAG_W-1:0] drop;
    r = '0;
    r.click_total = clicks[b];
    limit = (int'(cfg.buttons_in_use) > NUM_BUTTONS) ? NUM_BUTTONS
                                                      : int'(cfg.buttons_in_use);
    case (cmd)
      CMD_TICK: begin
        // ticks for buttons past the count in use leave the entry alone
        if (b < limit) r.changed = advance_button(b, raw ^ cfg.active_low_mask[b]);
        r.click_total = clicks[b];
        r.flags = flags[b];
      end
      CMD_READ: begin
        // report flags as they were, then drop the selected ones
        r.flags = flags[b];
        drop = '0;
        drop[F_PRESSED]  = clr[0];
        drop[F_RELEASED] = clr[1];
        drop[F_REPEAT]   = clr[2];
        drop[F_HELD]     = clr[3];
        flags[b] = flags[b] & ~drop;
      end
      CMD_TAKE: begin
        r.click_total = take_clicks(b, consider);
        r.flags = flags[b];
      end
      CMD_MATCH: begin
        if (clicks[b] == want_clicks) begin
          gap_tmr[b] = '0;
          clicks[b] = '0;
          r.clicks_matched = 1'b1;
        end
        r.flags = flags[b];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input report_t want, input string what,
                             input logic [7:0] exp_v, input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: button %0d command %0d %s expected %0d got %0d",
               $time, want.button, want.cmd, what, exp_v, got_v);
      n_fail++;
    end
  endtask

  // Track writes, check results, predict accepted items
  always @(posedge clk) begin : watch
    report_t w;
    if (rst) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        btn_mode[i] = MODE_WAIT;
        tick_tmr[i] = '0;
        gap_tmr[i]  = '0;
        clicks[i]   = '0;
        flags[i]    = '0;
      end
      cfg.buttons_in_use  = 5'd16;
      cfg.active_low_mask = 16'd0;
      cfg.bounce_ticks    = 16'd5;
      cfg.click_gap_ticks = 16'd30;
      cfg.hold_ticks      = 16'd100;
      cfg.repeat_ticks    = 16'd20;
      awaited_reports.delete();
      n_open = 0;
      n_fail = 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_BUTTONS:    cfg.buttons_in_use  = wr_data[4:0];
          REG_ACTIVE_LOW: cfg.active_low_mask = wr_data;
          REG_BOUNCE:     cfg.bounce_ticks    = wr_data;
          REG_CLICK_GAP:  cfg.click_gap_ticks = wr_data;
          REG_HOLD:       cfg.hold_ticks      = wr_data;
          REG_REPEAT:     cfg.repeat_ticks    = wr_data;
          default: ;
        endcase
      end
      if (done) begin
        if (awaited_reports.size() == 0) begin
          $display("%0t: result with no item waiting, expected none got click_total %0d",
                   $time, click_total);
          n_fail++;
        end else begin
          w = awaited_reports.pop_front();
          n_open--;
          check_field(w, "changed", 8'(w.res.changed), 8'(changed));
          check_field(w, "is_pressed", 8'(w.res.flags[F_ON_PRESS]), 8'(is_pressed));
          check_field(w, "press_event", 8'(w.res.flags[F_PRESSED]), 8'(press_event));
          check_field(w, "is_held", 8'(w.res.flags[F_ON_HOLD]), 8'(is_held));
          check_field(w, "hold_event", 8'(w.res.flags[F_HELD]), 8'(hold_event));
          check_field(w, "release_event", 8'(w.res.flags[F_RELEASED]),
                      8'(release_event));
          check_field(w, "repeat_event", 8'(w.res.flags[F_REPEAT]), 8'(repeat_event));
          check_field(w, "click_total", w.res.click_total, click_total);
          check_field(w, "clicks_matched", 8'(w.res.clicks_matched), 8'(clicks_matched));
        end
      end
      if (start && !busy) begin
        w.cmd    = command;
        w.button = button_index;
        w.res    = button_report(command, int'(button_index), raw_level, clear_mask,
                                 hold_aware, expected_clicks);
        awaited_reports.push_back(w);
        n_open++;
      end
    end
    fail_count <= n_fail;
    open_items <= n_open;
  end

endmodule

FILE: test/button_click_hold_repeat_fsm_unit_test.sv
`timescale 1ns / 1ps

module button_click_hold_repeat_fsm_unit_test import bchr_pkg::*;;

  // Indexes past the register list; writes there must be ignored
  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 105;

  logic                 clk             = 1'b0;
  logic                 rst             = 1'b1;
  logic                 start           = 1'b0;
  logic [1:0]           command         = CMD_TICK;
  logic [BTN_IDX_W-1:0] button_index    = '0;
  logic                 raw_level       = 1'b0;
  logic [3:0]           clear_mask      = '0;
  logic                 hold_aware      = 1'b0;
  logic [CLICK_W-1:0]   expected_clicks = '0;
  logic                 wr_en           = 1'b0;
  logic [REG_IDX_W-1:0] wr_index        = '0;
  logic [15:0]          wr_data         = '0;

  logic                 busy;
  logic                 done;
  logic                 changed;
  logic                 is_pressed;
  logic                 press_event;
  logic                 is_held;
  logic                 hold_event;
  logic                 release_event;
  logic                 repeat_event;
  logic [CLICK_W-1:0]   click_total;
  logic                 clicks_matched;

  int                   fail_count;
  int                   open_items;

  int                   idle_pct       = 0;
  int                   in_use         = 16;
  logic [15:0]          low_mask       = '0;
  logic [15:0]          plan           = '0;
  int                   items_sent     = 0;
  int                   ticks_sent     = 0;
  int                   settings_count = 0;

  button_click_hold_repeat_fsm_unit dut (.*);
  button_click_hold_repeat_fsm_checker watch (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bound the run
  initial begin
    #10_000_000;
    $display("Timed out with %0d items outstanding", open_items);
    $display("== FAIL ==");
    $finish;
  end

  // Present one item after a random idle gap and hold it until taken
  task automatic issue(input logic [1:0] cmd, input logic [3:0] idx, input logic lvl,
                       input logic [3:0] clr, input logic cons, input logic [7:0] expc);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    command         <= cmd;
    button_index    <= idx;
    raw_level       <= lvl;
    clear_mask      <= clr;
    hold_aware      <= cons;
    expected_clicks <= expc;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (cmd == CMD_TICK) ticks_sent++;
  endtask

  // Drop start and wait for every result to come back
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (open_items != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [15:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
  endtask

  // Write every register while the block is idle
  task automatic configure(input logic [15:0] n, input logic [15:0] mask,
                           input logic [15:0] bounce, input logic [15:0] gap,
                           input logic [15:0] hold, input logic [15:0] rpt);
    settle();
    write_reg(REG_BUTTONS, n);
    write_reg(REG_ACTIVE_LOW, mask);
    write_reg(REG_BOUNCE, bounce);
    write_reg(REG_CLICK_GAP, gap);
    write_reg(REG_HOLD, hold);
    write_reg(REG_REPEAT, rpt);
    write_reg(REG_SPARE_A, 16'($urandom));
    write_reg(REG_SPARE_B, 16'($urandom));
    wr_en <= 1'b0;
    in_use   = int'(n[4:0]);
    low_mask = mask;
    settings_count++;
  endtask

  // Mostly clean presses on in-use buttons, with some pin noise and stray queries
  task automatic random_item();
    int         b;
    int         pick;
    logic [1:0] cmd;
    logic       lvl;
    logic [7:0] expc;
    if ($urandom_range(99) < 85) b = $urandom_range(in_use - 1);
    else b = $urandom_range(15);
    pick = $urandom_range(99);
    if (pick < 70) begin
      cmd = CMD_TICK;
      if ($urandom_range(7) == 0) plan[b] = ~plan[b];
      lvl = plan[b] ^ low_mask[b];
      if ($urandom_range(9) == 0) lvl = 1'($urandom);
    end else begin
      cmd = (pick < 82) ? CMD_READ : (pick < 91) ? CMD_TAKE : CMD_MATCH;
      lvl = 1'($urandom);
    end
    expc = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
    issue(cmd, b[3:0], lvl, 4'($urandom), 1'($urandom), expc);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Query the cleared store under reset settings
    issue(CMD_READ, 4'd0, 1'b0, 4'h0, 1'b0, 8'd0);
    issue(CMD_TAKE, 4'd15, 1'b0, 4'h0, 1'b1, 8'd0);
    issue(CMD_MATCH, 4'd15, 1'b0, 4'h0, 1'b0, 8'd0);
    issue(CMD_MATCH, 4'd3, 1'b0, 4'h0, 1'b0, 8'hFF);
    issue(CMD_TICK, 4'd5, 1'b1, 4'h0, 1'b0, 8'd0);
    issue(CMD_READ, 4'd5, 1'b0, 4'hF, 1'b0, 8'd0);

    // Short thresholds; upper bits of the button count are masked off,
    // leaving 15 in use, and the top two buttons are active low
    configure(16'hFFEF, 16'hC000, 16'd1, 16'd2, 16'd1, 16'd1);
    repeat (5) issue(CMD_TICK, 4'd0, 1'b1, 4'h0, 1'b0, 8'd0);
    issue(CMD_READ, 4'd0, 1'b0, 4'hF, 1'b0, 8'd0);
    issue(CMD_TICK, 4'd0, 1'b0, 4'h0, 1'b0, 8'd0);
    issue(CMD_TAKE, 4'd0, 1'b0, 4'h0, 1'b1, 8'd0);
    issue(CMD_TICK, 4'd15, 1'b1, 4'h0, 1'b0, 8'd0);
    issue(CMD_READ, 4'd15, 1'b0, 4'h0, 1'b0, 8'd0);
    issue(CMD_TICK, 4'd14, 1'b0, 4'h0, 1'b0, 8'd0);
    issue(CMD_TICK, 4'd14, 1'b0, 4'h0, 1'b0, 8'd0);
    issue(CMD_TICK, 4'd14, 1'b1, 4'h0, 1'b0, 8'd0);
    issue(CMD_MATCH, 4'd14, 1'b0, 4'h0, 1'b0, 8'd1);
    issue(CMD_TAKE, 4'd14, 1'b0, 4'h0, 1'b0, 8'd0);
    issue(CMD_MATCH, 4'd14, 1'b0, 4'h0, 1'b0, 8'hFF);

    // Press one button into hold and repeat, release, then take the clicks
    // with and without the held flag standing
    configure(16'd16, 16'h0000, 16'd1, 16'd2, 16'd2, 16'd1);
    repeat (6) issue(CMD_TICK, 4'd1, 1'b1, 4'h0, 1'b0, 8'd0);
    issue(CMD_TICK, 4'd1, 1'b0, 4'h0, 1'b0, 8'd0);
    issue(CMD_TAKE, 4'd1, 1'b0, 4'h0, 1'b1, 8'd0);
    issue(CMD_READ, 4'd1, 1'b0, 4'h8, 1'b0, 8'd0);
    issue(CMD_TAKE, 4'd1, 1'b0, 4'h0, 1'b1, 8'd0);

    // Random phases over several settings and idle rates
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(16'd4, 16'($urandom), 16'($urandom_range(3, 1)),
                     16'($urandom_range(8, 1)), 16'($urandom_range(8, 1)),
                     16'($urandom_range(4, 1)));
        1: configure(16'd1, 16'($urandom), 16'd1, 16'd1, 16'd1, 16'd1);
        2: configure(16'd16, 16'($urandom), 16'($urandom_range(3, 1)),
                     16'($urandom_range(8, 1)), 16'($urandom_range(8, 1)),
                     16'($urandom_range(4, 1)));
        3: configure(16'd3, 16'($urandom), 16'($urandom_range(2, 1)),
                     16'hFFFF, 16'hFFFF, 16'hFFFF);
        4: configure(16'd2, 16'($urandom), 16'($urandom_range(3, 1)),
                     16'($urandom_range(8, 1)), 16'($urandom_range(8, 1)),
                     16'($urandom_range(4, 1)));
        default: configure(16'($urandom_range(16, 1)), 16'($urandom),
                           16'($urandom_range(3, 1)), 16'($urandom_range(8, 1)),
                           16'($urandom_range(8, 1)), 16'($urandom_range(4, 1)));
      endcase
      idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 56 : 18;
      repeat (ITEMS_PER_PHASE) random_item();
    end

    // Drain and report
    settle();
    idle_pct = 0;
    repeat (4) @(posedge clk);
    $display("Sent %0d items (%0d ticks) over %0d register settings at idle rates 0/56/18.",
             items_sent, ticks_sent, settings_count);
    $display("Covered debounce, click series, hold with repeat and ticks past the count.");
    if (fail_count == 0 && open_items == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
